@@ hw/rtl/qxm_pkg.sv @@
// Package: widths, register indexes and reset values for the X-frame motor mixer.
`default_nettype none

package qxm_pkg;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned STAGES   = 6;
  localparam int unsigned CFG_AW   = 2;

  localparam logic [CFG_AW-1:0] REG_THRUST_BASE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_THRUST_SCALE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DESAT_FLOOR  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_OUTPUT   = 2'd3;

  localparam logic [FIELD_W-1:0] THRUST_BASE_RST  = 16'd32768;
  localparam logic [FIELD_W-1:0] THRUST_SCALE_RST = 16'd32768;
  localparam logic [FIELD_W-1:0] DESAT_FLOOR_RST  = 16'd9830;
  localparam logic [FIELD_W-1:0] MIN_OUTPUT_RST   = 16'd6554;

  // Motor values: signed, 16 fractional bits
  localparam int unsigned MIX_W = 21;
  localparam int unsigned SFT_W = 22;
  localparam logic signed [MIX_W-1:0] ONE_MIX = 21'sd65536;
  localparam logic signed [SFT_W-1:0] ONE_SFT = 22'sd65536;

  localparam int unsigned NUM_MOTORS = 4;

endpackage

`default_nettype wire

@@ hw/rtl/quad_x_motor_mixer_desat.sv @@
// X-frame quadcopter motor mixer with desaturation, six-stage pipeline.
// Usage:
//   in_tdata carries throttle, roll, pitch and yaw commands (signed Q1.15).
//   out_tdata carries four motor setpoints, 0..65535 full scale.
//   cfg_wr_en/cfg_addr/cfg_wdata write thrust_base, thrust_scale,
//   desat_floor and min_output; write only while the pipeline is empty.
// Timing:
//   Throughput is one beat per cycle while out_tready holds no stage;
//   the stages are the throttle multiply, base sum, scale multiply,
//   motor mix, excess/shortfall search and the shift/clamp/scale
//   output stage.
// Reset:
//   rst_n low empties the pipeline and loads the register defaults
//   (base 0.5, scale 1.0, floor 0.15, min 0.1).
// Stall:
//   When out_tready is low, each full stage holds while the one after it
//   holds too; empty stages keep filling, so in_tready drops only once all
//   six stages hold beats. Nothing is dropped or repeated.
`default_nettype none

module quad_x_motor_mixer_desat (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // throttle[15:0], roll_command[31:16], pitch_command[47:32], yaw_command[63:48]
  input  wire  [63:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // motor_front_left[15:0], motor_rear_left[31:16],
  // motor_front_right[47:32], motor_rear_right[63:48]
  output logic [63:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  localparam int unsigned S  = qxm_pkg::STAGES;
  localparam int unsigned MW = qxm_pkg::MIX_W;
  localparam int unsigned VW = qxm_pkg::SFT_W;
  localparam int unsigned NM = qxm_pkg::NUM_MOTORS;

  logic [15:0] thrust_base_r, thrust_scale_r, desat_floor_r, min_output_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_base_r  <= qxm_pkg::THRUST_BASE_RST;
      thrust_scale_r <= qxm_pkg::THRUST_SCALE_RST;
      desat_floor_r  <= qxm_pkg::DESAT_FLOOR_RST;
      min_output_r   <= qxm_pkg::MIN_OUTPUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        qxm_pkg::REG_THRUST_BASE:  thrust_base_r  <= cfg_wdata;
        qxm_pkg::REG_THRUST_SCALE: thrust_scale_r <= cfg_wdata;
        qxm_pkg::REG_DESAT_FLOOR:  desat_floor_r  <= cfg_wdata;
        qxm_pkg::REG_MIN_OUTPUT:   min_output_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid chain and stage enables
  logic [S-1:0] vld_r;
  logic [S-1:0] en;

  always_comb begin
    en[S-1] = !vld_r[S-1] || out_tready;
    for (int k = S - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[S-1];

  // commands travel as doubled (Q.16) values
  logic signed [16:0] cmd1_r [3], cmd2_r [3], cmd3_r [3];

  // stage 1: throttle * base
  logic signed [16:0] thr_ext, base_ext;
  logic signed [33:0] p1_r;
  assign thr_ext  = {in_tdata[15], in_tdata[15:0]};
  assign base_ext = {1'b0, thrust_base_r};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r <= thr_ext * base_ext;
      for (int j = 0; j < 3; j++) begin
        cmd1_r[j] <= {in_tdata[16*(j+1) +: 16], 1'b0};
      end
    end
  end

  // stage 2: base + floor(product / 2^15)
  logic signed [18:0] sum_full;
  logic        [16:0] sum_r;
  assign sum_full = {3'b000, thrust_base_r} + 19'(p1_r >>> 15);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_r  <= sum_full[16:0];
      cmd2_r <= cmd1_r;
    end
  end

  // stage 3: sum * scale
  logic [32:0] p2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_r   <= 33'(sum_r) * 33'(thrust_scale_r);
      cmd3_r <= cmd2_r;
    end
  end

  // stage 4: mix; roll/pitch/yaw signs per motor
  logic signed [MW-1:0] thrust;
  logic signed [MW-1:0] r_w, p_w, y_w;
  logic signed [MW-1:0] mix [NM];
  logic signed [MW-1:0] m4_r [NM];

  assign thrust = MW'($signed({1'b0, p2_r[32:15]}));
  assign r_w    = MW'(cmd3_r[0]);
  assign p_w    = MW'(cmd3_r[1]);
  assign y_w    = MW'(cmd3_r[2]);

  always_comb begin
    mix[0] = thrust + r_w + p_w - y_w;
    mix[1] = thrust + r_w - p_w + y_w;
    mix[2] = thrust - r_w + p_w + y_w;
    mix[3] = thrust - r_w - p_w - y_w;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m4_r <= mix;
    end
  end

  // stage 5: largest excess over 1.0 and largest shortfall below floor
  logic signed [MW-1:0] floor_w;
  logic signed [MW-1:0] exc [NM], shf [NM];
  logic signed [MW-1:0] exc_a, exc_b, shf_a, shf_b, exc_max, shf_max;
  logic signed [MW-1:0] m5_r [NM];
  logic signed [MW-1:0] exc_r, shf_r;

  assign floor_w = MW'($signed({1'b0, desat_floor_r}));

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      exc[i] = (m4_r[i] > qxm_pkg::ONE_MIX) ? m4_r[i] - qxm_pkg::ONE_MIX : '0;
      shf[i] = (m4_r[i] < floor_w) ? floor_w - m4_r[i] : '0;
    end
    exc_a   = (exc[0] > exc[1]) ? exc[0] : exc[1];
    exc_b   = (exc[2] > exc[3]) ? exc[2] : exc[3];
    exc_max = (exc_a > exc_b) ? exc_a : exc_b;
    shf_a   = (shf[0] > shf[1]) ? shf[0] : shf[1];
    shf_b   = (shf[2] > shf[3]) ? shf[2] : shf[3];
    shf_max = (shf_a > shf_b) ? shf_a : shf_b;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m5_r  <= m4_r;
      exc_r <= exc_max;
      shf_r <= shf_max;
    end
  end

  // stage 6: shift, clamp to [min_output, 1.0], scale by 65535/65536
  logic signed [VW-1:0] minv;
  logic signed [VW-1:0] v [NM];
  logic signed [VW-1:0] vc [NM];
  logic        [63:0]   out_nxt;
  logic        [63:0]   out_r;

  assign minv = VW'($signed({1'b0, min_output_r}));

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      v[i]  = VW'(m5_r[i]) - VW'(exc_r) + VW'(shf_r);
      vc[i] = (v[i] < minv) ? minv : v[i];
      if (vc[i] > qxm_pkg::ONE_SFT) begin
        vc[i] = qxm_pkg::ONE_SFT;
      end
      // floor(v * 65535 / 65536) is v - 1 for v in 1..65536
      out_nxt[16*i +: 16] = (vc[i] == '0) ? 16'd0 : 16'(vc[i] - VW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire

@@ sim/quad_x_motor_mixer_desat_checker.sv @@
// Checker for the X-frame motor mixer: predicts setpoints per command beat and compares.
module quad_x_motor_mixer_desat_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  // throttle[15:0], roll_command[31:16], pitch_command[47:32], yaw_command[63:48]
  input  wire  [63:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  // motor_front_left[15:0], motor_rear_left[31:16],
  // motor_front_right[47:32], motor_rear_right[63:48]
  input  wire  [63:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_addr,
  input  wire  [15:0] cfg_wdata,
  output int unsigned fail_count,
  output int unsigned setpoints_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] throttle;
  } stick_cmd_t;

  typedef struct packed {
    logic [15:0] rear_right;
    logic [15:0] front_right;
    logic [15:0] rear_left;
    logic [15:0] front_left;
  } motor_set_t;

  localparam longint UNITY       = 65536;
  localparam longint FULL_SCALE  = 65535;
  localparam int unsigned MAX_REPORTS = 10;

  logic [15:0] base_q;
  logic [15:0] scale_q;
  logic [15:0] floor_q;
  logic [15:0] min_q;

  motor_set_t  setpoint_q[$];
  int unsigned mismatches = 0;

  initial begin
    fail_count    = 0;
    setpoints_due = 0;
  end

  function automatic motor_set_t mix_motors(stick_cmd_t c);
    longint thr, rl, pt, yw, base, sum, thrust, excess, lift, v;
    longint m[qxm_pkg::NUM_MOTORS];
    logic [15:0] lvl[qxm_pkg::NUM_MOTORS];
    motor_set_t res;
    thr    = c.throttle;
    rl     = 2 * longint'(c.roll);
    pt     = 2 * longint'(c.pitch);
    yw     = 2 * longint'(c.yaw);
    base   = longint'(base_q);
    sum    = base + ((thr * base) >>> 15);
    thrust = (sum * longint'(scale_q)) >>> 15;
    m[0]   = thrust + rl + pt - yw;
    m[1]   = thrust + rl - pt + yw;
    m[2]   = thrust - rl + pt + yw;
    m[3]   = thrust - rl - pt - yw;
    excess = 0;
    lift   = 0;
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      if (m[i] > UNITY) begin
        if (m[i] - UNITY > excess) excess = m[i] - UNITY;
      end else if (m[i] < longint'(floor_q)) begin
        if (longint'(floor_q) - m[i] > lift) lift = longint'(floor_q) - m[i];
      end
    end
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      v = m[i] - excess + lift;
      if (v < longint'(min_q)) v = longint'(min_q);
      if (v > UNITY) v = UNITY;
      lvl[i] = 16'((v * FULL_SCALE) >>> 16);
    end
    res.front_left  = lvl[0];
    res.rear_left   = lvl[1];
    res.front_right = lvl[2];
    res.rear_right  = lvl[3];
    return res;
  endfunction

  function automatic void check_motor(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : track
    motor_set_t want;
    motor_set_t got;
    if (!rst_n) begin
      base_q  = qxm_pkg::THRUST_BASE_RST;
      scale_q = qxm_pkg::THRUST_SCALE_RST;
      floor_q = qxm_pkg::DESAT_FLOOR_RST;
      min_q   = qxm_pkg::MIN_OUTPUT_RST;
      setpoint_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          qxm_pkg::REG_THRUST_BASE:  base_q  = cfg_wdata;
          qxm_pkg::REG_THRUST_SCALE: scale_q = cfg_wdata;
          qxm_pkg::REG_DESAT_FLOOR:  floor_q = cfg_wdata;
          qxm_pkg::REG_MIN_OUTPUT:   min_q   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        setpoint_q.push_back(mix_motors(stick_cmd_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = motor_set_t'(out_tdata);
        if (setpoint_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t unexpected output beat %h", $time, out_tdata);
        end else begin
          want = setpoint_q.pop_front();
          check_motor("motor_front_left",  want.front_left,  got.front_left);
          check_motor("motor_rear_left",   want.rear_left,   got.rear_left);
          check_motor("motor_front_right", want.front_right, got.front_right);
          check_motor("motor_rear_right",  want.rear_right,  got.rear_right);
        end
      end
    end
    fail_count    <= mismatches;
    setpoints_due <= setpoint_q.size();
  end

endmodule

@@ sim/quad_x_motor_mixer_desat_tb.sv @@
// Testbench top: clock, reset, command and register stimulus, and the final verdict.
module quad_x_motor_mixer_desat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT        = 21;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  localparam logic signed [15:0] S_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN  = 16'sh8000;
  localparam logic signed [15:0] S_HALF = 16'sh4000;
  localparam logic signed [15:0] S_ZERO = 16'sh0000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;

  int unsigned fail_count;
  int unsigned setpoints_due;

  logic        no_idle   = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_ack  = 0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quad_x_motor_mixer_desat u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  quad_x_motor_mixer_desat_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .setpoints_due (setpoints_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("quad_x_motor_mixer_desat_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_cmd(input logic signed [15:0] thr, input logic signed [15:0] roll,
                          input logic signed [15:0] pitch, input logic signed [15:0] yaw);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yaw, pitch, roll, thr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (setpoints_due != 0) @(posedge clk);
    repeat (qxm_pkg::STAGES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [qxm_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] base, input logic [15:0] scale,
                           input logic [15:0] lvl_floor, input logic [15:0] lvl_min);
    put_reg(qxm_pkg::REG_THRUST_BASE, base);
    put_reg(qxm_pkg::REG_THRUST_SCALE, scale);
    put_reg(qxm_pkg::REG_DESAT_FLOOR, lvl_floor);
    put_reg(qxm_pkg::REG_MIN_OUTPUT, lvl_min);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_level(input int unsigned style);
    logic signed [15:0] corner[8];
    corner = '{S_MIN, -16'sd1, S_ZERO, 16'sd1, S_MAX, S_HALF, -S_HALF, 16'sd11469};
    case (style)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(8192)) - 16'd4096;
      2:       return corner[$urandom_range(7)];
      default: return 16'($urandom_range(24000)) - 16'd12000;
    endcase
  endfunction

  task automatic send_random_cmd();
    int unsigned sel;
    int unsigned style;
    sel   = $urandom_range(9);
    style = (sel < 3) ? 0 : (sel < 6) ? 3 : (sel < 8) ? 1 : 2;
    send_cmd(pick_level(style == 1 ? 0 : style), pick_level(style),
             pick_level(style), pick_level(style));
  endtask

  initial begin
    logic [15:0] regs[4];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_cmd(S_ZERO, S_ZERO, S_ZERO, S_ZERO);
    send_cmd(S_MAX,  S_ZERO, S_ZERO, S_ZERO);
    send_cmd(S_MIN,  S_ZERO, S_ZERO, S_ZERO);
    send_cmd(S_MAX,  S_MAX,  S_MAX,  S_MAX);
    send_cmd(S_MIN,  S_MIN,  S_MIN,  S_MIN);
    send_cmd(S_ZERO, S_HALF, S_ZERO, S_ZERO);       // two motors land on exactly 1.0
    send_cmd(S_ZERO, 16'sd11469, S_ZERO, S_ZERO);   // two motors land on the floor
    send_cmd(S_ZERO, S_MAX,  S_ZERO, S_ZERO);       // excess and shortfall together
    send_cmd(S_ZERO, S_ZERO, S_MAX,  S_ZERO);
    send_cmd(S_ZERO, S_ZERO, S_ZERO, S_MAX);
    send_cmd(S_ZERO, S_ZERO, S_ZERO, S_MIN);
    send_cmd(S_ZERO, S_MIN,  S_ZERO, S_ZERO);
    send_cmd(S_ZERO, S_ZERO, S_MIN,  S_ZERO);
    send_cmd(S_MAX,  S_ZERO, S_MIN,  S_MAX);
    send_cmd(S_MIN,  S_MAX,  S_MIN,  S_MAX);
    send_cmd(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_cmd(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_cmd(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    send_cmd(S_HALF, 16'sd2000, -16'sd3000, 16'sd1000);
    send_cmd(-S_HALF, 16'sd500, 16'sd500, -16'sd500);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       regs = '{16'd32768, 16'd32768, 16'd9830, 16'd6554};
        1:       regs = '{16'd0, 16'd0, 16'd0, 16'd0};
        2:       regs = '{16'd65535, 16'd32768, 16'd65535, 16'd65535};
        3:       regs = '{16'd65535, 16'd65535, 16'd0, 16'd0};      // scale near 2.0
        4:       regs = '{16'd16384, 16'd49152, 16'd20000, 16'd3000};
        default: regs = '{16'($urandom_range(65535)), 16'($urandom_range(32768)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535))};
      endcase
      load_regs(regs[0], regs[1], regs[2], regs[3]);
      no_idle <= (ph == 2);
      if (ph == 1 || ph == 5) hold_req <= hold_req + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
        send_random_cmd();
      end
    end
    wait_drained();
    repeat (2 * qxm_pkg::STAGES) @(posedge clk);

    if (fail_count == 0 && setpoints_due == 0) begin
      $display("quad_x_motor_mixer_desat_tb: PASS");
    end else begin
      $display("quad_x_motor_mixer_desat_tb: FAIL");
    end
    $finish;
  end

endmodule
